@@ rtl/core/ssd_pkg.sv @@
// Shared constants for the segment-to-segment distance pipeline.
// No dependencies; used by ssd_ratio, ssd_isqrt and the top level.
`default_nettype none

package ssd_pkg;

   // fraction bits of the closest-point parameters s and t
   localparam int SC_FRAC = 29;

   // width of the difference-vector accumulators and the squared length
   localparam int VW = 64;

   // width of the square root result
   localparam int RW = VW / 2;

   // divisor that turns 1.0 into the 1e-6 threshold
   localparam int THR_DIV = 1000000;

endpackage

`default_nettype wire

@@ rtl/core/ssd_delay.sv @@
// Fixed-depth shift line that keeps side data aligned with the pipeline.
// No dependencies.
`default_nettype none

module ssd_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

@@ rtl/core/ssd_dot.sv @@
// Edge vectors u, v, w and the five dot products a..e, three stages.
// No dependencies.
`default_nettype none

module ssd_dot #(
   parameter int CB = 32
) (
   input  wire logic               clock,
   input  wire logic signed [CB-1:0] pa [3],
   input  wire logic signed [CB-1:0] pb [3],
   input  wire logic signed [CB-1:0] pc [3],
   input  wire logic signed [CB-1:0] pd [3],
   output logic signed [2*CB+3:0]  dot_a,
   output logic signed [2*CB+3:0]  dot_b,
   output logic signed [2*CB+3:0]  dot_c,
   output logic signed [2*CB+3:0]  dot_d,
   output logic signed [2*CB+3:0]  dot_e,
   output logic signed [CB:0]      vec_u [3],
   output logic signed [CB:0]      vec_v [3],
   output logic signed [CB:0]      vec_w [3]
);

   localparam int DW = CB + 1;
   localparam int PW = 2 * DW + 2;

   logic signed [DW-1:0]   u1_ff [3], v1_ff [3], w1_ff [3];
   logic signed [DW-1:0]   u2_ff [3], v2_ff [3], w2_ff [3];
   logic signed [DW-1:0]   u3_ff [3], v3_ff [3], w3_ff [3];
   logic signed [2*DW-1:0] uu_ff [3], uv_ff [3], vv_ff [3], uw_ff [3], vw_ff [3];
   logic signed [PW-1:0]   a_ff, b_ff, c_ff, d_ff, e_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         u1_ff[i] <= DW'(pb[i]) - DW'(pa[i]);
         v1_ff[i] <= DW'(pd[i]) - DW'(pc[i]);
         w1_ff[i] <= DW'(pa[i]) - DW'(pc[i]);
         uu_ff[i] <= u1_ff[i] * u1_ff[i];
         uv_ff[i] <= u1_ff[i] * v1_ff[i];
         vv_ff[i] <= v1_ff[i] * v1_ff[i];
         uw_ff[i] <= u1_ff[i] * w1_ff[i];
         vw_ff[i] <= v1_ff[i] * w1_ff[i];
         u2_ff[i] <= u1_ff[i];
         v2_ff[i] <= v1_ff[i];
         w2_ff[i] <= w1_ff[i];
         u3_ff[i] <= u2_ff[i];
         v3_ff[i] <= v2_ff[i];
         w3_ff[i] <= w2_ff[i];
      end
      a_ff <= PW'(uu_ff[0]) + PW'(uu_ff[1]) + PW'(uu_ff[2]);
      b_ff <= PW'(uv_ff[0]) + PW'(uv_ff[1]) + PW'(uv_ff[2]);
      c_ff <= PW'(vv_ff[0]) + PW'(vv_ff[1]) + PW'(vv_ff[2]);
      d_ff <= PW'(uw_ff[0]) + PW'(uw_ff[1]) + PW'(uw_ff[2]);
      e_ff <= PW'(vw_ff[0]) + PW'(vw_ff[1]) + PW'(vw_ff[2]);
   end

   assign dot_a = a_ff;
   assign dot_b = b_ff;
   assign dot_c = c_ff;
   assign dot_d = d_ff;
   assign dot_e = e_ff;
   assign vec_u = u3_ff;
   assign vec_v = v3_ff;
   assign vec_w = w3_ff;

endmodule

`default_nettype wire

@@ rtl/core/ssd_wmul.sv @@
// Wide signed multiplier: magnitudes split in halves, four partial products.
// Four stages: magnitude, partial products, merge, sign. No dependencies.
`default_nettype none

module ssd_wmul #(
   parameter int AW = 68
) (
   input  wire logic                  clock,
   input  wire logic signed [AW-1:0]  x,
   input  wire logic signed [AW-1:0]  y,
   output logic signed [2*AW-1:0]     p
);

   localparam int HL = (AW + 1) / 2;
   localparam int HH = AW - HL;

   logic [AW-1:0]        xm_ff, ym_ff;
   logic                 neg1_ff, neg2_ff, neg3_ff;
   logic [2*HL-1:0]      pll_ff;
   logic [HL+HH-1:0]     plh_ff, phl_ff;
   logic [2*HH-1:0]      phh_ff;
   logic [HL+HH:0]       mid;
   logic [2*AW-1:0]      mag_in, mag_ff;
   logic signed [2*AW-1:0] p_ff;

   always_comb begin
      mid    = (HL+HH+1)'(plh_ff) + (HL+HH+1)'(phl_ff);
      mag_in = {phh_ff, pll_ff} + ((2*AW)'(mid) << HL);
   end

   always_ff @(posedge clock) begin
      xm_ff   <= x[AW-1] ? $unsigned(-x) : $unsigned(x);
      ym_ff   <= y[AW-1] ? $unsigned(-y) : $unsigned(y);
      neg1_ff <= x[AW-1] ^ y[AW-1];
      pll_ff  <= xm_ff[HL-1:0] * ym_ff[HL-1:0];
      plh_ff  <= xm_ff[HL-1:0] * ym_ff[AW-1:HL];
      phl_ff  <= xm_ff[AW-1:HL] * ym_ff[HL-1:0];
      phh_ff  <= xm_ff[AW-1:HL] * ym_ff[AW-1:HL];
      neg2_ff <= neg1_ff;
      mag_ff  <= mag_in;
      neg3_ff <= neg2_ff;
      p_ff    <= neg3_ff ? -$signed(mag_ff) : $signed(mag_ff);
   end

   assign p = p_ff;

endmodule

`default_nettype wire

@@ rtl/core/ssd_ratio.sv @@
// Pipelined restoring divider for a clamped parameter n/d in [0,1].
// One quotient bit per stage; depends on ssd_pkg.
`default_nettype none

module ssd_ratio #(
   parameter int NW = 138,
   parameter int FB = 16
) (
   input  wire logic                 clock,
   input  wire logic signed [NW-1:0] num,
   input  wire logic signed [NW-1:0] den,
   output logic [ssd_pkg::SC_FRAC:0] ratio
);

   localparam int QF = ssd_pkg::SC_FRAC;
   localparam logic [NW-1:0] ONE_Q = NW'(1) << (4 * FB);
   localparam logic signed [NW-1:0] THR = $signed(ONE_Q / NW'(ssd_pkg::THR_DIV));

   logic [NW-1:0] rem_ff  [QF+1];
   logic [NW-1:0] den_ff  [QF+1];
   logic [QF-1:0] q_ff    [QF+1];
   logic          zero_ff [QF+1];
   logic          full_ff [QF+1];
   logic [QF:0]   res_ff;

   // small or non-positive numerator, non-positive denominator: zero; n >= d: one
   always_ff @(posedge clock) begin
      rem_ff[0]  <= $unsigned(num);
      den_ff[0]  <= $unsigned(den);
      q_ff[0]    <= '0;
      zero_ff[0] <= (num <= 0) || (den <= 0) || (num < THR);
      full_ff[0] <= num >= den;
   end

   for (genvar k = 0; k < QF; k++) begin : g_step
      logic [NW:0] sh;
      logic [NW:0] df;
      logic        ge;

      always_comb begin
         sh = {rem_ff[k], 1'b0};
         df = sh - {1'b0, den_ff[k]};
         ge = sh >= {1'b0, den_ff[k]};
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= ge ? df[NW-1:0] : sh[NW-1:0];
         den_ff[k+1]  <= den_ff[k];
         q_ff[k+1]    <= {q_ff[k][QF-2:0], ge};
         zero_ff[k+1] <= zero_ff[k];
         full_ff[k+1] <= full_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (zero_ff[QF]) begin
         res_ff <= '0;
      end else if (full_ff[QF]) begin
         res_ff <= (QF+1)'(1) << QF;
      end else begin
         res_ff <= {1'b0, q_ff[QF]};
      end
   end

   assign ratio = res_ff;

endmodule

`default_nettype wire

@@ rtl/core/ssd_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on ssd_pkg for the operand width.
`default_nettype none

module ssd_isqrt (
   input  wire logic                   clock,
   input  wire logic [ssd_pkg::VW-1:0] radicand,
   output logic      [ssd_pkg::RW-1:0] root
);

   localparam int VW = ssd_pkg::VW;
   localparam int NS = ssd_pkg::RW;

   logic [VW-1:0] x_ff [NS+1];
   logic [VW-1:0] r_ff [NS+1];

   always_ff @(posedge clock) begin
      x_ff[0] <= radicand;
      r_ff[0] <= '0;
   end

   for (genvar k = 0; k < NS; k++) begin : g_bit
      localparam logic [VW-1:0] BIT = VW'(1) << (VW - 2 - 2 * k);
      logic [VW-1:0] trial;
      logic          ge;

      always_comb begin
         trial = r_ff[k] + BIT;
         ge    = x_ff[k] >= trial;
      end

      always_ff @(posedge clock) begin
         x_ff[k+1] <= ge ? x_ff[k] - trial : x_ff[k];
         r_ff[k+1] <= ge ? (r_ff[k] >> 1) + BIT : r_ff[k] >> 1;
      end
   end

   assign root = r_ff[NS][NS-1:0];

endmodule

`default_nettype wire

@@ rtl/core/segment_segment_distance_3d.sv @@
// Top level: minimum distance between two 3D segments, fully pipelined.
// Depends on ssd_pkg, ssd_delay, ssd_dot, ssd_wmul, ssd_ratio, ssd_isqrt.
//
//  channel   ports                          transfer when
//  --------  -----------------------------  -------------------------------
//  request   start, busy, req_{a..d}_{x,y,z}  start high, busy low
//  response  rsp_strobe, rsp_distance       rsp_strobe high (one cycle)
//
// One pair per cycle, sustained, while reset is low. A pair passes through the dot
// products, wide multiply, clamps, divider, distance, root and output register in turn.
// The divider and the square root, one bit per stage, make up most of the depth.
// busy is high only while reset is high; reset clears the valid bits only.
// The receiver cannot stall; nothing inside ever waits.
`default_nettype none

module segment_segment_distance_3d #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [COORD_BITS-1:0] req_a_x,
   input  wire logic signed [COORD_BITS-1:0] req_a_y,
   input  wire logic signed [COORD_BITS-1:0] req_a_z,
   input  wire logic signed [COORD_BITS-1:0] req_b_x,
   input  wire logic signed [COORD_BITS-1:0] req_b_y,
   input  wire logic signed [COORD_BITS-1:0] req_b_z,
   input  wire logic signed [COORD_BITS-1:0] req_c_x,
   input  wire logic signed [COORD_BITS-1:0] req_c_y,
   input  wire logic signed [COORD_BITS-1:0] req_c_z,
   input  wire logic signed [COORD_BITS-1:0] req_d_x,
   input  wire logic signed [COORD_BITS-1:0] req_d_y,
   input  wire logic signed [COORD_BITS-1:0] req_d_z,
   output logic                              rsp_strobe,
   output logic [COORD_BITS-1:0]             rsp_distance
);

   localparam int CB = COORD_BITS;
   localparam int FB = FRAC_BITS;
   localparam int QF = ssd_pkg::SC_FRAC;
   localparam int VW = ssd_pkg::VW;
   localparam int RW = ssd_pkg::RW;
   localparam int DW = CB + 1;          // edge vector component
   localparam int PW = 2 * DW + 2;      // dot product
   localparam int MW = 2 * PW;          // product of two dot products
   localparam int NA = MW + 2;
   localparam int NB = PW + 2 * FB + 2;
   localparam int NC = 4 * FB + 2;
   localparam int NW = (NA > NB) ? ((NA > NC) ? NA : NC) : ((NB > NC) ? NB : NC);
   localparam int EW = PW + 1;          // e+b, -d, b-d
   localparam int PRW = DW + QF + 2;    // s*u, t*v

   localparam int L_DOT = 3;
   localparam int L_MUL = 4;
   localparam int L_RAT = QF + 2;
   localparam int L_SQ  = RW + 1;
   localparam int LAT   = L_DOT + L_MUL + 3 + L_RAT + 6 + L_SQ + 1;
   localparam int T_RAT = L_DOT + L_MUL + 3 + L_RAT;   // ratio ready

   localparam logic [NW-1:0] ONE_Q = NW'(1) << (4 * FB);
   localparam logic signed [NW-1:0] ONE = $signed(ONE_Q);
   localparam logic signed [NW-1:0] THR = $signed(ONE_Q / NW'(ssd_pkg::THR_DIV));
   localparam logic [32:0] DMAX = (33'd1 << CB) - 33'd1;

   // ---------------------------------------------------------------- valid bits
   logic             accept;
   logic [LAT-1:0]   vld_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // ---------------------------------------------------------------- dot products
   logic signed [CB-1:0] pa [3], pb [3], pc [3], pd [3];
   logic signed [PW-1:0] a3, b3, c3, d3, e3;
   logic signed [DW-1:0] u3 [3], v3 [3], w3 [3];

   assign pa = '{req_a_x, req_a_y, req_a_z};
   assign pb = '{req_b_x, req_b_y, req_b_z};
   assign pc = '{req_c_x, req_c_y, req_c_z};
   assign pd = '{req_d_x, req_d_y, req_d_z};

   ssd_dot #(.CB(CB)) u_dot (
      .clock (clock),
      .pa    (pa),
      .pb    (pb),
      .pc    (pc),
      .pd    (pd),
      .dot_a (a3),
      .dot_b (b3),
      .dot_c (c3),
      .dot_d (d3),
      .dot_e (e3),
      .vec_u (u3),
      .vec_v (v3),
      .vec_w (w3)
   );

   // ---------------------------------------------------------------- wide products
   logic signed [MW-1:0] ac7, bb7, be7, cd7, ae7, bd7;

   ssd_wmul #(.AW(PW)) u_mul_ac (.clock(clock), .x(a3), .y(c3), .p(ac7));
   ssd_wmul #(.AW(PW)) u_mul_bb (.clock(clock), .x(b3), .y(b3), .p(bb7));
   ssd_wmul #(.AW(PW)) u_mul_be (.clock(clock), .x(b3), .y(e3), .p(be7));
   ssd_wmul #(.AW(PW)) u_mul_cd (.clock(clock), .x(c3), .y(d3), .p(cd7));
   ssd_wmul #(.AW(PW)) u_mul_ae (.clock(clock), .x(a3), .y(e3), .p(ae7));
   ssd_wmul #(.AW(PW)) u_mul_bd (.clock(clock), .x(b3), .y(d3), .p(bd7));

   logic [5*PW-1:0]      dots7;
   logic signed [PW-1:0] a7, b7, c7, d7, e7;

   ssd_delay #(.WIDTH(5*PW), .DEPTH(L_MUL)) u_dly_dots (
      .clock (clock),
      .din   ({a3, b3, c3, d3, e3}),
      .dout  (dots7)
   );

   assign {a7, b7, c7, d7, e7} = dots7;

   // ---------------------------------------------------------------- numerators
   logic signed [NW-1:0] dd_ff, snr_ff, tnr_ff;
   logic signed [PW-1:0] a8_ff, c8_ff, e8_ff;
   logic signed [EW-1:0] eb8_ff, m08_ff, m18_ff;

   always_ff @(posedge clock) begin
      dd_ff  <= NW'(ac7) - NW'(bb7);
      snr_ff <= NW'(be7) - NW'(cd7);
      tnr_ff <= NW'(ae7) - NW'(bd7);
      a8_ff  <= a7;
      c8_ff  <= c7;
      e8_ff  <= e7;
      eb8_ff <= EW'(e7) + EW'(b7);
      m08_ff <= -EW'(d7);
      m18_ff <= EW'(b7) - EW'(d7);
   end

   // ---------------------------------------------------------------- first clamp
   // near-parallel: s = 0 over 1.0; otherwise clamp s to [0, DD] and refit t
   logic signed [NW-1:0] el8, cl8, ebl8;
   logic signed [NW-1:0] sn_in, sd_in, tn_in, td_in;
   logic signed [NW-1:0] sn9_ff, sd9_ff, tn9_ff, td9_ff;
   logic signed [PW-1:0] a9_ff;
   logic signed [EW-1:0] m09_ff, m19_ff;
   logic                 m0neg_ff, m0big_ff, m1neg_ff, m1big_ff;

   always_comb begin
      el8  = NW'(e8_ff) <<< (2 * FB);
      cl8  = NW'(c8_ff) <<< (2 * FB);
      ebl8 = NW'(eb8_ff) <<< (2 * FB);
      if (dd_ff < THR) begin
         sn_in = '0;
         sd_in = ONE;
         tn_in = el8;
         td_in = cl8;
      end else if (snr_ff < 0) begin
         sn_in = '0;
         sd_in = dd_ff;
         tn_in = el8;
         td_in = cl8;
      end else if (snr_ff > dd_ff) begin
         sn_in = dd_ff;
         sd_in = dd_ff;
         tn_in = ebl8;
         td_in = cl8;
      end else begin
         sn_in = snr_ff;
         sd_in = dd_ff;
         tn_in = tnr_ff;
         td_in = dd_ff;
      end
   end

   always_ff @(posedge clock) begin
      sn9_ff   <= sn_in;
      sd9_ff   <= sd_in;
      tn9_ff   <= tn_in;
      td9_ff   <= td_in;
      a9_ff    <= a8_ff;
      m09_ff   <= m08_ff;
      m19_ff   <= m18_ff;
      m0neg_ff <= m08_ff < 0;
      m1neg_ff <= m18_ff < 0;
      m0big_ff <= m08_ff > EW'(a8_ff);
      m1big_ff <= m18_ff > EW'(a8_ff);
   end

   // ---------------------------------------------------------------- second clamp
   // t out of [0,1]: pin t to an end and recompute s against that end
   logic                 tneg, tbig, mneg, mbig;
   logic signed [EW-1:0] msel;
   logic signed [NW-1:0] sn_c2, sd_c2, tn_c2;
   logic signed [NW-1:0] sn10_ff, sd10_ff, tn10_ff, td10_ff;

   always_comb begin
      tneg  = tn9_ff < 0;
      tbig  = tn9_ff > td9_ff;
      mneg  = tneg ? m0neg_ff : m1neg_ff;
      mbig  = tneg ? m0big_ff : m1big_ff;
      msel  = tneg ? m09_ff : m19_ff;
      sn_c2 = sn9_ff;
      sd_c2 = sd9_ff;
      tn_c2 = tn9_ff;
      if (tneg || tbig) begin
         tn_c2 = tneg ? '0 : td9_ff;
         if (mneg) begin
            sn_c2 = '0;
         end else if (mbig) begin
            sn_c2 = sd9_ff;
         end else begin
            sn_c2 = NW'(msel) <<< (2 * FB);
            sd_c2 = NW'(a9_ff) <<< (2 * FB);
         end
      end
   end

   always_ff @(posedge clock) begin
      sn10_ff <= sn_c2;
      sd10_ff <= sd_c2;
      tn10_ff <= tn_c2;
      td10_ff <= td9_ff;
   end

   // ---------------------------------------------------------------- s and t
   logic [QF:0] sc, tc;

   ssd_ratio #(.NW(NW), .FB(FB)) u_ratio_s (
      .clock (clock),
      .num   (sn10_ff),
      .den   (sd10_ff),
      .ratio (sc)
   );

   ssd_ratio #(.NW(NW), .FB(FB)) u_ratio_t (
      .clock (clock),
      .num   (tn10_ff),
      .den   (td10_ff),
      .ratio (tc)
   );

   logic [9*DW-1:0]      vecs_r;
   logic signed [DW-1:0] ur [3], vr [3], wr [3];

   ssd_delay #(.WIDTH(9*DW), .DEPTH(T_RAT - L_DOT)) u_dly_vecs (
      .clock (clock),
      .din   ({u3[0], u3[1], u3[2], v3[0], v3[1], v3[2], w3[0], w3[1], w3[2]}),
      .dout  (vecs_r)
   );

   assign {ur[0], ur[1], ur[2], vr[0], vr[1], vr[2], wr[0], wr[1], wr[2]} = vecs_r;

   // ---------------------------------------------------------------- difference vector
   // w + s*u - t*v with SC_FRAC extra bits, rounded half away from zero
   logic signed [PRW-1:0] psu_ff [3], ptv_ff [3];
   logic signed [DW-1:0]  wp_ff [3];
   logic signed [VW-1:0]  val_ff [3];
   logic [VW-1:0]         mag_ff [3];
   logic [VW-1:0]         rnd [3];
   logic [31:0]           comp_ff [3];
   logic [2:0]            satc_ff;
   logic [VW-1:0]         sq_ff [3];
   logic                  satq_ff;
   logic [VW:0]           sum1, sum2;
   logic [VW-1:0]         sum_ff;
   logic                  sat_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd[i] = (mag_ff[i] + (VW'(1) << (QF - 1))) >> QF;
      end
      sum1 = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
      sum2 = {1'b0, sum1[VW-1:0]} + {1'b0, sq_ff[2]};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         psu_ff[i]  <= $signed({1'b0, sc}) * ur[i];
         ptv_ff[i]  <= $signed({1'b0, tc}) * vr[i];
         wp_ff[i]   <= wr[i];
         val_ff[i]  <= (VW'(wp_ff[i]) <<< QF) + VW'(psu_ff[i]) - VW'(ptv_ff[i]);
         mag_ff[i]  <= val_ff[i][VW-1] ? $unsigned(-val_ff[i]) : $unsigned(val_ff[i]);
         comp_ff[i] <= rnd[i][31:0];
         satc_ff[i] <= |rnd[i][VW-1:32];
         sq_ff[i]   <= comp_ff[i] * comp_ff[i];
      end
      satq_ff <= |satc_ff;
      sum_ff  <= sum2[VW-1:0];
      sat_ff  <= satq_ff || sum1[VW] || sum2[VW];
   end

   // ---------------------------------------------------------------- root and output
   logic [RW-1:0] root;
   logic          sat_root;
   logic [CB-1:0] dist_ff;

   ssd_isqrt u_isqrt (
      .clock    (clock),
      .radicand (sum_ff),
      .root     (root)
   );

   ssd_delay #(.WIDTH(1), .DEPTH(L_SQ)) u_dly_sat (
      .clock (clock),
      .din   (sat_ff),
      .dout  (sat_root)
   );

   always_ff @(posedge clock) begin
      if (sat_root || ({1'b0, root} > DMAX)) begin
         dist_ff <= DMAX[CB-1:0];
      end else begin
         dist_ff <= root[CB-1:0];
      end
   end

   assign rsp_strobe   = vld_ff[LAT-1];
   assign rsp_distance = dist_ff;

   // ---------------------------------------------------------------- checks
   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("response strobe right after reset");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_strobe)
      else $error("accepted pair produced no response");

   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[T_RAT-1] |-> (sc <= ((QF+1)'(1) << QF)) && (tc <= ((QF+1)'(1) << QF)))
      else $error("closest-point parameter above one");

endmodule

`default_nettype wire
